@@ src/mbq_pkg.sv @@
// shared types and constants for the multichannel biquad filter
// no dependencies; imported by mbq_ctrl, mbq_dp, multichannel_biquad_iir, mbq_checker and tb_top
`default_nettype none

package mbq_pkg;

    // configuration register file
    localparam int REG_WIDTH  = 20;
    localparam int CHAN_WIDTH = 3;
    localparam int NUM_REGS   = 6;
    localparam int ADDR_WIDTH = 5;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_BITS   = 3;

    // register indexes (byte address / 4)
    localparam logic [IDX_BITS-1:0] REG_INPUT_GAIN = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_FF_COEF_0  = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_FF_COEF_1  = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_FF_COEF_2  = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_FB_COEF_1  = 3'd4;
    localparam logic [IDX_BITS-1:0] REG_FB_COEF_2  = 3'd5;

    // reset values, 1.0 in Q4.16 for gain and direct term
    localparam logic signed [REG_WIDTH-1:0] GAIN_RESET = 20'sd65536;
    localparam logic signed [REG_WIDTH-1:0] FF0_RESET  = 20'sd65536;
    localparam logic signed [REG_WIDTH-1:0] COEF_ZERO  = 20'sd0;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_GAIN,
        S_SCALE,
        S_MAC2,
        S_MAC3,
        S_MAC4,
        S_MAC5,
        S_MAC6,
        S_OUT
    } t_state;

    // multiplier operand pair
    typedef enum logic [2:0] {
        MUL_GAIN,
        MUL_FF0,
        MUL_FF1,
        MUL_FF2,
        MUL_FB1,
        MUL_FB2
    } t_mul_sel;

    // accumulator operation
    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } t_acc_op;

    // controller to datapath commands
    typedef struct packed {
        logic     load;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     xs_en;
        t_acc_op  acc_op;
        logic     out_wr;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

@@ src/multichannel_biquad_iir.sv @@
// top level of the multichannel biquad filter: register port, sequencer, datapath
// depends on mbq_pkg, mbq_ctrl and mbq_dp
//
// usage:
//   input channel: a word (i_sample_in, i_channel) is taken when i_in_valid is
//   high and o_in_stall is low. output channel: a word (o_sample_out,
//   o_channel_out) is taken when o_out_valid is high and i_out_stall is low.
//   gain and the five coefficients sit on the register port at byte address
//   4*index, signed Q4.16 in bits 19:0; write them only while the block is idle.
//   one word at a time runs through one shared multiplier and accumulator:
//   gain, then five multiply-accumulate steps, then round and saturate.
//   a new word is taken only once the last one has gone to the output register;
//   the time per word is set by the six passes through the
//   multiplier plus capture and output steps.
//   a stalled output holds its word; the next word is still taken and runs
//   until its result is ready, then waits for the output register to free.
//   reset: all histories read as zero, gain and first feedforward return to 1.0,
//   the other coefficients to zero, and no output is pending.
`default_nettype none

module multichannel_biquad_iir
    import mbq_pkg::*;
#(
    parameter int CHANNELS       = 8,
    parameter int SAMPLE_WIDTH   = 16,
    parameter int COEF_FRAC_BITS = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // input words
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_sample_in,
    input  wire logic [CHAN_WIDTH-1:0]          i_channel,
    // output words
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]      o_sample_out,
    output logic [CHAN_WIDTH-1:0]               o_channel_out,
    // register port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [ADDR_WIDTH-1:0]          paddr,
    input  wire logic [DATA_WIDTH-1:0]          pwdata,
    output logic [DATA_WIDTH-1:0]               prdata,
    output logic                                pready
);

    logic signed [REG_WIDTH-1:0] r_gain;
    logic signed [REG_WIDTH-1:0] r_ff0;
    logic signed [REG_WIDTH-1:0] r_ff1;
    logic signed [REG_WIDTH-1:0] r_ff2;
    logic signed [REG_WIDTH-1:0] r_fb1;
    logic signed [REG_WIDTH-1:0] r_fb2;

    logic [IDX_BITS-1:0]         reg_idx;
    logic                        reg_wr;
    logic signed [REG_WIDTH-1:0] wr_val;
    logic signed [REG_WIDTH-1:0] rd_val;
    t_dp_cmd                     cmd;
    t_dp_stat                    stat;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_WIDTH-1:2];
    assign reg_wr  = psel && penable && pwrite && pready;
    assign wr_val  = pwdata[REG_WIDTH-1:0];

    // register writes, unknown indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
            r_ff0  <= FF0_RESET;
            r_ff1  <= COEF_ZERO;
            r_ff2  <= COEF_ZERO;
            r_fb1  <= COEF_ZERO;
            r_fb2  <= COEF_ZERO;
        end else if (reg_wr) begin
            case (reg_idx)
                REG_INPUT_GAIN: r_gain <= wr_val;
                REG_FF_COEF_0:  r_ff0  <= wr_val;
                REG_FF_COEF_1:  r_ff1  <= wr_val;
                REG_FF_COEF_2:  r_ff2  <= wr_val;
                REG_FB_COEF_1:  r_fb1  <= wr_val;
                REG_FB_COEF_2:  r_fb2  <= wr_val;
                default: begin
                end
            endcase
        end
    end

    // register reads, sign extended
    always_comb begin
        case (reg_idx)
            REG_INPUT_GAIN: rd_val = r_gain;
            REG_FF_COEF_0:  rd_val = r_ff0;
            REG_FF_COEF_1:  rd_val = r_ff1;
            REG_FF_COEF_2:  rd_val = r_ff2;
            REG_FB_COEF_1:  rd_val = r_fb1;
            REG_FB_COEF_2:  rd_val = r_fb2;
            default:        rd_val = '0;
        endcase
    end

    assign prdata = DATA_WIDTH'(rd_val);

    // sequencer
    mbq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // datapath
    mbq_dp #(
        .CHANNELS       (CHANNELS),
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_sample_in   (i_sample_in),
        .i_channel     (i_channel),
        .i_gain        (r_gain),
        .i_ff0         (r_ff0),
        .i_ff1         (r_ff1),
        .i_ff2         (r_ff2),
        .i_fb1         (r_fb1),
        .i_fb2         (r_fb2),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_sample_out  (o_sample_out),
        .o_channel_out (o_channel_out)
    );

endmodule

`default_nettype wire

@@ src/mbq_ctrl.sv @@
// sequencer for the biquad: steps one word through gain, five macs and output
// depends on mbq_pkg
`default_nettype none

module mbq_ctrl
    import mbq_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state      = r_state;
        o_in_stall   = 1'b1;
        o_cmd        = '0;
        o_cmd.mul_sel = MUL_GAIN;
        o_cmd.acc_op = ACC_HOLD;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_GAIN;
                end
            end
            S_GAIN: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_GAIN;
                n_state       = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.xs_en   = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_FF1;
                n_state       = S_MAC2;
            end
            S_MAC2: begin
                o_cmd.acc_op  = ACC_LOAD;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_FF2;
                n_state       = S_MAC3;
            end
            S_MAC3: begin
                o_cmd.acc_op  = ACC_ADD;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_FB1;
                n_state       = S_MAC4;
            end
            S_MAC4: begin
                o_cmd.acc_op  = ACC_SUB;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_FB2;
                n_state       = S_MAC5;
            end
            S_MAC5: begin
                o_cmd.acc_op  = ACC_SUB;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_FF0;
                n_state       = S_MAC6;
            end
            S_MAC6: begin
                o_cmd.acc_op = ACC_ADD;
                n_state      = S_OUT;
            end
            S_OUT: begin
                // wait for room in the output register
                if (i_stat.out_free) begin
                    o_cmd.out_wr = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    // a blocked result keeps the sequencer waiting
    a_out_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !i_stat.out_free) |=> (r_state == S_OUT))
        else $error("sequencer left output state without room");

    // no second word is taken while one is in flight
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_in_stall)
        else $error("input not stalled after a word was taken");
`endif

endmodule

`default_nettype wire

@@ src/mbq_dp.sv @@
// biquad datapath: shared multiplier, accumulator, per-channel history memory
// and output register; depends on mbq_pkg
`default_nettype none

module mbq_dp
    import mbq_pkg::*;
#(
    parameter int CHANNELS       = 8,
    parameter int SAMPLE_WIDTH   = 16,
    parameter int COEF_FRAC_BITS = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire t_dp_cmd                        i_cmd,
    output t_dp_stat                            o_stat,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_sample_in,
    input  wire logic [CHAN_WIDTH-1:0]          i_channel,
    input  wire logic signed [REG_WIDTH-1:0]    i_gain,
    input  wire logic signed [REG_WIDTH-1:0]    i_ff0,
    input  wire logic signed [REG_WIDTH-1:0]    i_ff1,
    input  wire logic signed [REG_WIDTH-1:0]    i_ff2,
    input  wire logic signed [REG_WIDTH-1:0]    i_fb1,
    input  wire logic signed [REG_WIDTH-1:0]    i_fb2,
    input  wire logic                           i_out_stall,
    output logic                                o_out_valid,
    output logic signed [SAMPLE_WIDTH-1:0]      o_sample_out,
    output logic [CHAN_WIDTH-1:0]               o_channel_out
);

    localparam int SW    = SAMPLE_WIDTH;
    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ROW_W = 4 * SW;
    localparam int P_W   = SW + REG_WIDTH;
    localparam int ACC_W = SW + REG_WIDTH + 4;
    localparam int MOD_W = 7;

    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] SAT_HI   = (ACC_W'(1) <<< (SW - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] SAT_LO   = -(ACC_W'(1) <<< (SW - 1));

    // channel number folded onto the available histories
    function automatic logic [IDX_W-1:0] chan_index(input logic [CHAN_WIDTH-1:0] ch);
        logic [MOD_W-1:0] v;
        v = MOD_W'(ch);
        for (int k = 0; k < 8; k++) begin
            if (v >= MOD_W'(CHANNELS)) begin
                v = v - MOD_W'(CHANNELS);
            end
        end
        return v[IDX_W-1:0];
    endfunction

    // round half up, drop fraction, clamp to sample range
    function automatic logic signed [SW-1:0] rnd_sat(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        t = (v + RND_HALF) >>> COEF_FRAC_BITS;
        if (t > SAT_HI) begin
            return SAT_HI[SW-1:0];
        end else if (t < SAT_LO) begin
            return SAT_LO[SW-1:0];
        end
        return t[SW-1:0];
    endfunction

    logic [ROW_W-1:0]              r_hist_mem [CHANNELS];
    logic [CHANNELS-1:0]           r_hist_vld;
    logic [ROW_W-1:0]              r_row;
    logic                          r_hist_ok;
    logic [IDX_W-1:0]              r_idx;
    logic signed [SW-1:0]          r_sample;
    logic [CHAN_WIDTH-1:0]         r_chan;
    logic signed [P_W-1:0]         r_prod;
    logic signed [SW-1:0]          r_xs;
    logic signed [ACC_W-1:0]       r_acc;
    logic                          r_out_valid;
    logic signed [SW-1:0]          r_sample_out;
    logic [CHAN_WIDTH-1:0]         r_chan_out;

    logic [IDX_W-1:0]              rd_idx;
    logic signed [SW-1:0]          h_x1;
    logic signed [SW-1:0]          h_x2;
    logic signed [SW-1:0]          h_y1;
    logic signed [SW-1:0]          h_y2;
    logic signed [SW-1:0]          mul_a;
    logic signed [REG_WIDTH-1:0]   mul_b;
    logic signed [P_W-1:0]         mul_res;
    logic signed [ACC_W-1:0]       prod_ext;
    logic signed [SW-1:0]          y_new;

    assign rd_idx = chan_index(i_channel);

    // history fields, zero until the channel is first written
    assign h_x1 = r_hist_ok ? r_row[SW-1:0]        : '0;
    assign h_x2 = r_hist_ok ? r_row[2*SW-1:SW]     : '0;
    assign h_y1 = r_hist_ok ? r_row[3*SW-1:2*SW]   : '0;
    assign h_y2 = r_hist_ok ? r_row[4*SW-1:3*SW]   : '0;

    // input capture and history read
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sample <= i_sample_in;
            r_chan   <= i_channel;
            r_idx    <= rd_idx;
            r_row    <= r_hist_mem[rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist_ok <= 1'b0;
        end else if (i_cmd.load) begin
            r_hist_ok <= r_hist_vld[rd_idx];
        end
    end

    // history write, shift of both delay pairs
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_wr) begin
            r_hist_mem[r_idx] <= {h_y1, y_new, h_x1, r_xs};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist_vld <= '0;
        end else if (i_cmd.out_wr) begin
            r_hist_vld[r_idx] <= 1'b1;
        end
    end

    // multiplier operand select
    always_comb begin
        case (i_cmd.mul_sel)
            MUL_GAIN: begin
                mul_a = r_sample;
                mul_b = i_gain;
            end
            MUL_FF0: begin
                mul_a = r_xs;
                mul_b = i_ff0;
            end
            MUL_FF1: begin
                mul_a = h_x1;
                mul_b = i_ff1;
            end
            MUL_FF2: begin
                mul_a = h_x2;
                mul_b = i_ff2;
            end
            MUL_FB1: begin
                mul_a = h_y1;
                mul_b = i_fb1;
            end
            MUL_FB2: begin
                mul_a = h_y2;
                mul_b = i_fb2;
            end
            default: begin
                mul_a = r_sample;
                mul_b = i_gain;
            end
        endcase
    end

    assign mul_res  = P_W'(mul_a) * P_W'(mul_b);
    assign prod_ext = ACC_W'(r_prod);
    assign y_new    = rnd_sat(r_acc);

    // product register and scaled input
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= mul_res;
        end
        if (i_cmd.xs_en) begin
            r_xs <= rnd_sat(prod_ext);
        end
    end

    // accumulator
    always_ff @(posedge i_clk) begin
        case (i_cmd.acc_op)
            ACC_LOAD: r_acc <= prod_ext;
            ACC_ADD:  r_acc <= r_acc + prod_ext;
            ACC_SUB:  r_acc <= r_acc - prod_ext;
            default:  r_acc <= r_acc;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_wr) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_wr) begin
            r_sample_out <= y_new;
            r_chan_out   <= r_chan;
        end
    end

    assign o_stat.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid     = r_out_valid;
    assign o_sample_out    = r_sample_out;
    assign o_channel_out   = r_chan_out;

`ifndef ASSERT_OFF
    // a written result shows up with the channel of its word
    a_out_chan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_wr |=> (r_out_valid && o_channel_out == $past(r_chan)))
        else $error("result missing or carrying the wrong channel");

    // the accumulator starts only once the scaled input is settled
    a_acc_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.acc_op == ACC_LOAD) |-> $past(i_cmd.xs_en))
        else $error("accumulator loaded out of order");
`endif

endmodule

`default_nettype wire

@@ verif/mbq_checker.sv @@
// checker for multichannel_biquad_iir: follows register writes and both word channels,
// predicts each filtered word and compares it with what the block delivers
// depends on mbq_pkg
module mbq_checker
    import mbq_pkg::*;
#(
    parameter int CHANNELS       = 8,
    parameter int SAMPLE_WIDTH   = 16,
    parameter int COEF_FRAC_BITS = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // input channel
    input  wire logic                           i_in_valid,
    input  wire logic                           i_in_stall,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_sample_in,
    input  wire logic [CHAN_WIDTH-1:0]          i_channel,
    // output channel
    input  wire logic                           i_out_valid,
    input  wire logic                           i_out_stall,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_sample_out,
    input  wire logic [CHAN_WIDTH-1:0]          i_channel_out,
    // register port
    input  wire logic                           i_psel,
    input  wire logic                           i_penable,
    input  wire logic                           i_pwrite,
    input  wire logic                           i_pready,
    input  wire logic [ADDR_WIDTH-1:0]          i_paddr,
    input  wire logic [DATA_WIDTH-1:0]          i_pwdata,
    // status for the testbench top
    output int                                  o_mismatches,
    output int                                  o_pending
);

    typedef struct packed {
        logic [SAMPLE_WIDTH-1:0] sample;
        logic [CHAN_WIDTH-1:0]   chan;
    } t_filtered;

    // expected words, oldest first
    t_filtered filtered_q[$];

    // filter settings and per-channel history as the block should hold them
    logic signed [REG_WIDTH-1:0]    coef_reg[NUM_REGS];
    logic signed [SAMPLE_WIDTH-1:0] hist_x1[CHANNELS];
    logic signed [SAMPLE_WIDTH-1:0] hist_x2[CHANNELS];
    logic signed [SAMPLE_WIDTH-1:0] hist_y1[CHANNELS];
    logic signed [SAMPLE_WIDTH-1:0] hist_y2[CHANNELS];

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    // drop the fraction bits rounding half up, then clamp to the sample range
    function automatic longint round_clamp(input longint acc);
        longint hi;
        longint lo;
        longint r;
        hi = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
        lo = -hi - 1;
        r  = (acc + (longint'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
        if (r > hi) return hi;
        if (r < lo) return lo;
        return r;
    endfunction

    // gain, direct form I biquad, history shift; queues the expected word
    task automatic run_biquad(input logic signed [SAMPLE_WIDTH-1:0] sample,
                              input logic [CHAN_WIDTH-1:0] chan);
        longint scaled;
        longint acc;
        longint filtered;
        int     h;
        t_filtered word;
        h      = int'(chan) % CHANNELS;
        scaled = round_clamp(longint'(sample) * longint'(coef_reg[REG_INPUT_GAIN]));
        acc    = longint'(coef_reg[REG_FF_COEF_0]) * scaled
               + longint'(coef_reg[REG_FF_COEF_1]) * longint'(hist_x1[h])
               + longint'(coef_reg[REG_FF_COEF_2]) * longint'(hist_x2[h])
               - longint'(coef_reg[REG_FB_COEF_1]) * longint'(hist_y1[h])
               - longint'(coef_reg[REG_FB_COEF_2]) * longint'(hist_y2[h]);
        filtered   = round_clamp(acc);
        hist_x2[h] = hist_x1[h];
        hist_x1[h] = scaled[SAMPLE_WIDTH-1:0];
        hist_y2[h] = hist_y1[h];
        hist_y1[h] = filtered[SAMPLE_WIDTH-1:0];
        word.sample = filtered[SAMPLE_WIDTH-1:0];
        word.chan   = chan;
        filtered_q.push_back(word);
    endtask

    always @(posedge i_clk) begin : watch
        logic [IDX_BITS-1:0] idx;
        t_filtered           want;
        if (!i_rst_n) begin
            filtered_q.delete();
            coef_reg[REG_INPUT_GAIN] = GAIN_RESET;
            coef_reg[REG_FF_COEF_0]  = FF0_RESET;
            coef_reg[REG_FF_COEF_1]  = COEF_ZERO;
            coef_reg[REG_FF_COEF_2]  = COEF_ZERO;
            coef_reg[REG_FB_COEF_1]  = COEF_ZERO;
            coef_reg[REG_FB_COEF_2]  = COEF_ZERO;
            for (int c = 0; c < CHANNELS; c++) begin
                hist_x1[c] = '0;
                hist_x2[c] = '0;
                hist_y1[c] = '0;
                hist_y2[c] = '0;
            end
        end else begin
            // register write, indexes past the list are dropped
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                idx = i_paddr[ADDR_WIDTH-1:2];
                if (idx < NUM_REGS) begin
                    coef_reg[idx] = i_pwdata[REG_WIDTH-1:0];
                end
            end
            // accepted input word
            if (i_in_valid && !i_in_stall) begin
                run_biquad(i_sample_in, i_channel);
            end
            // accepted output word against the oldest expectation
            if (i_out_valid && !i_out_stall) begin
                if (filtered_q.size() == 0) begin
                    if (o_mismatches < 10) begin
                        $display("unexpected word: sample %0d channel %0d",
                                 i_sample_out, i_channel_out);
                    end
                    o_mismatches++;
                end else begin
                    want = filtered_q.pop_front();
                    if (i_sample_out !== want.sample || i_channel_out !== want.chan) begin
                        if (o_mismatches < 10) begin
                            $display("word mismatch: sample exp %0d got %0d, channel exp %0d got %0d",
                                     $signed(want.sample), i_sample_out,
                                     want.chan, i_channel_out);
                        end
                        o_mismatches++;
                    end
                end
            end
        end
        o_pending = filtered_q.size();
    end

endmodule

@@ verif/tb_top.sv @@
// testbench top for multichannel_biquad_iir: clock, reset, register writes and word
// traffic with random gaps and stalls; mbq_checker does the prediction and comparison
// depends on mbq_pkg, multichannel_biquad_iir and mbq_checker
module tb_top;
    import mbq_pkg::*;

    localparam int CHANNELS       = 8;
    localparam int SAMPLE_WIDTH   = 16;
    localparam int COEF_FRAC_BITS = 16;
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_WORDS    = 150;
    localparam int HOLD_AT_WORD   = 500;
    localparam int HOLD_CYCLES    = 400;

    // indexes past the register list, writes there must have no effect
    localparam logic [IDX_BITS-1:0] REG_BEYOND_LO = 3'd6;
    localparam logic [IDX_BITS-1:0] REG_BEYOND_HI = 3'd7;

    localparam logic signed [REG_WIDTH-1:0] COEF_MAX  = 20'sd524287;
    localparam logic signed [REG_WIDTH-1:0] COEF_MIN  = -20'sd524288;
    localparam logic signed [REG_WIDTH-1:0] COEF_ONE  = 20'sd65536;
    localparam logic signed [REG_WIDTH-1:0] COEF_HALF = 20'sd32768;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_in_valid;
    logic                           o_in_stall;
    logic signed [SAMPLE_WIDTH-1:0] i_sample_in;
    logic [CHAN_WIDTH-1:0]          i_channel;
    logic                           o_out_valid;
    logic                           i_out_stall;
    logic signed [SAMPLE_WIDTH-1:0] o_sample_out;
    logic [CHAN_WIDTH-1:0]          o_channel_out;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [ADDR_WIDTH-1:0]          paddr;
    logic [DATA_WIDTH-1:0]          pwdata;
    logic [DATA_WIDTH-1:0]          prdata;
    logic                           pready;

    int mismatches;
    int pending;
    int cycle_count = 0;
    int words_sent  = 0;
    bit no_idle     = 0;

    multichannel_biquad_iir #(
        .CHANNELS       (CHANNELS),
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_sample_in   (i_sample_in),
        .i_channel     (i_channel),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_sample_out  (o_sample_out),
        .o_channel_out (o_channel_out),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    mbq_checker #(
        .CHANNELS       (CHANNELS),
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_sample_in   (i_sample_in),
        .i_channel     (i_channel),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_sample_out  (o_sample_out),
        .i_channel_out (o_channel_out),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("multichannel_biquad_iir test failed");
            $finish;
        end
    end

    // output stall: open runs, short stalls, a few long ones, and one long hold-off
    // once the traffic is under way so the block fills and stalls its input
    initial begin : receiver
        bit held_off;
        int roll;
        held_off    = 1'b0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held_off && words_sent >= HOLD_AT_WORD) begin
                held_off    = 1'b1;
                i_out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_out_stall = 1'b0;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 40) begin
                    i_out_stall = 1'b0;
                    repeat ($urandom_range(1, 30)) @(negedge i_clk);
                end else if (roll < 90) begin
                    i_out_stall = 1'b1;
                    repeat ($urandom_range(1, 3)) @(negedge i_clk);
                    i_out_stall = 1'b0;
                    repeat ($urandom_range(0, 4)) @(negedge i_clk);
                end else begin
                    i_out_stall = 1'b1;
                    repeat ($urandom_range(10, 40)) @(negedge i_clk);
                    i_out_stall = 1'b0;
                end
            end
        end
    end

    // idle cycles between input words, none while a gapless stretch runs
    function automatic int sender_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // offer one word, hold it until taken, then maybe idle
    task automatic send_word(input logic signed [SAMPLE_WIDTH-1:0] sample,
                             input logic [CHAN_WIDTH-1:0] chan);
        int gap;
        i_in_valid  = 1'b1;
        i_sample_in = sample;
        i_channel   = chan;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        words_sent++;
        @(negedge i_clk);
        gap = sender_gap();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // stop offering and wait until every expected word has come out
    task automatic drain();
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // register write: setup cycle, then access cycle until pready
    task automatic write_reg(input logic [IDX_BITS-1:0] idx,
                             input logic signed [REG_WIDTH-1:0] value);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = $urandom;
        pwdata[REG_WIDTH-1:0] = value;
        @(negedge i_clk);
        penable = 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // new filter setting, only once the block has gone idle
    task automatic load_coefs(input logic signed [REG_WIDTH-1:0] gain,
                              input logic signed [REG_WIDTH-1:0] ff0,
                              input logic signed [REG_WIDTH-1:0] ff1,
                              input logic signed [REG_WIDTH-1:0] ff2,
                              input logic signed [REG_WIDTH-1:0] fb1,
                              input logic signed [REG_WIDTH-1:0] fb2);
        drain();
        write_reg(REG_INPUT_GAIN, gain);
        write_reg(REG_FF_COEF_0, ff0);
        write_reg(REG_FF_COEF_1, ff1);
        write_reg(REG_FF_COEF_2, ff2);
        write_reg(REG_FB_COEF_1, fb1);
        write_reg(REG_FB_COEF_2, fb2);
    endtask

    // random setting: full range, a plausible filter, or extremes only
    task automatic random_setting();
        logic signed [REG_WIDTH-1:0] v[NUM_REGS];
        int style;
        style = $urandom_range(0, 2);
        for (int r = 0; r < NUM_REGS; r++) begin
            case (style)
                0: begin
                    v[r] = REG_WIDTH'($urandom);
                end
                1: begin
                    if (r == REG_INPUT_GAIN || r == REG_FF_COEF_0)
                        v[r] = REG_WIDTH'($urandom_range(16384, 131072));
                    else if (r == REG_FB_COEF_1)
                        v[r] = REG_WIDTH'(int'($urandom_range(0, 240000)) - 120000);
                    else if (r == REG_FB_COEF_2)
                        v[r] = REG_WIDTH'($urandom_range(0, 60000));
                    else
                        v[r] = REG_WIDTH'(int'($urandom_range(0, 80000)) - 40000);
                    if (r == REG_INPUT_GAIN && $urandom_range(0, 3) == 0) v[r] = -v[r];
                end
                default: begin
                    case ($urandom_range(0, 3))
                        0: v[r] = COEF_MAX;
                        1: v[r] = COEF_MIN;
                        2: v[r] = COEF_ZERO;
                        default: v[r] = COEF_ONE;
                    endcase
                end
            endcase
        end
        load_coefs(v[REG_INPUT_GAIN], v[REG_FF_COEF_0], v[REG_FF_COEF_1],
                   v[REG_FF_COEF_2], v[REG_FB_COEF_1], v[REG_FB_COEF_2]);
        if ($urandom_range(0, 1) == 0) write_reg(REG_BEYOND_LO, REG_WIDTH'($urandom));
        if ($urandom_range(0, 1) == 0) write_reg(REG_BEYOND_HI, REG_WIDTH'($urandom));
    endtask

    // random words: runs of words on one channel so histories build up
    task automatic random_words(input int count);
        logic [CHAN_WIDTH-1:0]          chan;
        logic signed [SAMPLE_WIDTH-1:0] sample;
        int roll;
        chan = CHAN_WIDTH'($urandom_range(0, CHANNELS - 1));
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 49) == 0) no_idle = ~no_idle;
            if ($urandom_range(0, 2) == 0) chan = CHAN_WIDTH'($urandom_range(0, CHANNELS - 1));
            roll = $urandom_range(0, 99);
            if (roll < 50)
                sample = SAMPLE_WIDTH'($urandom);
            else if (roll < 85)
                sample = SAMPLE_WIDTH'(int'($urandom_range(0, 4000)) - 2000);
            else if (roll < 93)
                sample = ($urandom_range(0, 1) == 0) ? 16'sh7fff : 16'sh8000;
            else
                sample = SAMPLE_WIDTH'(int'($urandom_range(0, 6)) - 3);
            send_word(sample, chan);
        end
    endtask

    // stimulus and verdict
    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_sample_in = '0;
        i_channel   = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset setting passes samples through: extremes and other values, one on every channel
        send_word(16'sh7fff, 3'd0);
        send_word(16'sh8000, 3'd1);
        send_word(16'sd0, 3'd2);
        send_word(-16'sd1, 3'd3);
        send_word(16'sd1, 3'd4);
        send_word(16'sd12345, 3'd5);
        send_word(-16'sd12346, 3'd6);
        send_word(16'sh5555, 3'd7);

        // largest gain and mixed extreme taps: saturation of both stages,
        // writes past the register list must not disturb anything
        load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN);
        write_reg(REG_BEYOND_LO, COEF_MIN);
        write_reg(REG_BEYOND_HI, COEF_MAX);
        send_word(16'sh7fff, 3'd0);
        send_word(16'sh8000, 3'd0);
        send_word(16'sd1, 3'd0);
        send_word(-16'sd1, 3'd7);
        send_word(16'sh7fff, 3'd7);

        // most negative gain and coefficients
        load_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
        send_word(16'sh7fff, 3'd2);
        send_word(16'sh8000, 3'd2);
        send_word(16'sd3, 3'd2);
        send_word(-16'sd3, 3'd5);

        // half gain: exact ties in the rounding step
        load_coefs(COEF_HALF, COEF_ONE, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO);
        send_word(16'sd1, 3'd4);
        send_word(-16'sd1, 3'd4);
        send_word(16'sd3, 3'd4);
        send_word(-16'sd3, 3'd4);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            random_setting();
            random_words(PHASE_WORDS);
        end

        drain();
        repeat (20) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("multichannel_biquad_iir test passed");
        end else begin
            $display("multichannel_biquad_iir test failed");
        end
        $finish;
    end

endmodule
